// ===== sv/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared constants and helpers for the barometric
// sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // Datapath widths of the shared serial units
  localparam int MulAw = 64;   // accumulator / multiplicand width
  localparam int MulBw = 32;   // multiplier width, consumed one bit per cycle
  localparam int DivW  = 32;   // divider width, one quotient bit per cycle

  // Configuration register indexes
  localparam logic [2:0] CfgAc1Ac2 = 3'd0;
  localparam logic [2:0] CfgAc3Ac4 = 3'd1;
  localparam logic [2:0] CfgAc5Ac6 = 3'd2;
  localparam logic [2:0] CfgB1B2   = 3'd3;
  localparam logic [2:0] CfgMcMd   = 3'd4;
  localparam logic [2:0] CfgOss    = 3'd5;

  // Operation codes
  localparam logic OpTemp  = 1'b0;
  localparam logic OpPress = 1'b1;

  // Compensation constants
  localparam logic signed [63:0] B6Offset  = 64'sd4000;
  localparam logic        [15:0] B7Scale   = 16'd50000;
  localparam logic signed [31:0] CorrSq    = 32'sd3038;
  localparam logic signed [31:0] CorrLin   = -32'sd7357;
  localparam logic signed [63:0] CorrConst = 64'sd3791;
  localparam logic signed [63:0] ValMax    = 64'sd1048575;
  localparam logic signed [63:0] ValMin    = -64'sd1048576;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] n,
                                                   input logic [5:0] k);
    logic signed [63:0] bias;
    bias = n[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (n + bias) >>> k;
  endfunction

  // Clamp to the 21-bit signed result range
  function automatic logic signed [20:0] sat_value(input logic signed [63:0] v);
    logic signed [20:0] r;
    if (v > ValMax) begin
      r = 21'sh0FFFFF;
    end else if (v < ValMin) begin
      r = 21'sh100000;
    end else begin
      r = $signed(v[20:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bsc_mul.sv =====
// ----------------------------------------------------------------------------
// bsc_mul: serial signed multiplier
// Shift-add, one multiplier bit per cycle; stops early once the remaining
// multiplier bits are all sign bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_mul
  import bsc_pkg::*;
#(
  parameter int Aw = MulAw,
  parameter int Bw = MulBw
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [Aw-1:0] a_i,
  input  wire logic signed [Bw-1:0] b_i,
  output logic                      done_o,
  output logic signed [Aw-1:0]      prod_o
);

  logic                 busy_q, done_q;
  logic signed [Aw-1:0] a_q, acc_q;
  logic signed [Bw-1:0] b_q;
  logic                 b_zero, b_ones, fin;

  assign b_zero = (b_q == '0);
  assign b_ones = &b_q;
  assign fin    = busy_q && (b_zero || b_ones);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_ones) begin
        // remaining multiplier is -1
        acc_q <= acc_q - a_q;
      end else if (!b_zero) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= a_q <<< 1;
        b_q <= b_q >>> 1;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== sv/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div
  import bsc_pkg::*;
#(
  parameter int W = DivW
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  localparam int CntW = $clog2(W + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [W:0]      shifted, diff;
  logic            ge, fin;

  assign shifted = {rem_q, quo_q[W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fin     = busy_q && (cnt_q == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (fin) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/baro_sensor_compensation_top.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top: barometric sensor integer compensation
// Turns raw temperature / pressure readings into 0.1 degC and Pa values.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The time from accept to result
// is set by a shared shift-add multiplier that consumes one multiplier
// bit per cycle (it stops once the remaining bits are pure sign) and by
// a restoring divider that makes one quotient bit per cycle; a full
// pressure reading runs ten multiplications and one divide back to back
// through these units. The result sits in an output register, so a new
// transaction is taken while the previous result waits. A temperature
// reading stores the B5 term that later pressure readings use; before
// any temperature reading B5 is zero. A zero divisor yields value 0 with
// divide_error set, and B5 is left untouched. Write configuration only
// while the block is idle; writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_top
  import bsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [23:0] raw_reading_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic signed [20:0] value_o,
  output logic             divide_error_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_T_MUL = 15'b000000000000010,
    S_T_DIV = 15'b000000000000100,
    S_P_SQ  = 15'b000000000001000,
    S_P_X1  = 15'b000000000010000,
    S_P_B3  = 15'b000000000100000,
    S_P_C1  = 15'b000000001000000,
    S_P_C2  = 15'b000000010000000,
    S_P_B4  = 15'b000000100000000,
    S_P_B7  = 15'b000001000000000,
    S_P_DIV = 15'b000010000000000,
    S_P_Y1A = 15'b000100000000000,
    S_P_Y1B = 15'b001000000000000,
    S_P_Y2  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  // configuration
  logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
  logic [1:0]  oss_q;
  logic signed [31:0] b5_q;

  logic signed [15:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
  logic        [15:0] ac4_u, ac5_u, ac6_u;

  assign ac1_s = $signed(ac1_ac2_q[31:16]);
  assign ac2_s = $signed(ac1_ac2_q[15:0]);
  assign ac3_s = $signed(ac3_ac4_q[31:16]);
  assign ac4_u = ac3_ac4_q[15:0];
  assign ac5_u = ac5_ac6_q[31:16];
  assign ac6_u = ac5_ac6_q[15:0];
  assign b1_s  = $signed(b1_b2_q[31:16]);
  assign b2_s  = $signed(b1_b2_q[15:0]);
  assign mc_s  = $signed(mc_md_q[31:16]);
  assign md_s  = $signed(mc_md_q[15:0]);

  // working registers
  logic               op_q;
  logic [23:0]        ut_up_q;
  logic signed [63:0] x_q, b6_q, sq_q, den_q, y1_q;
  logic [31:0]        b3_q, u_q, b4_q, b7_q;
  logic [63:0]        p_q;
  logic               res_err_q;
  logic signed [20:0] res_val_q;

  // output register
  logic               out_valid_q, out_kind_q, out_err_q;
  logic signed [20:0] out_val_q;

  // shared units
  logic                      mul_start, mul_done;
  logic signed [MulAw-1:0]   mul_a, mul_prod;
  logic signed [MulBw-1:0]   mul_b;
  logic                      div_start, div_done;
  logic [DivW-1:0]           div_dividend, div_divisor, div_quot;

  bsc_mul #(.Aw(MulAw), .Bw(MulBw)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  bsc_div #(.W(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic in_acc, out_load, is_work, is_div, unit_done, step_fire;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign is_work   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign is_div    = (state_q == S_T_DIV) || (state_q == S_P_DIV);
  assign unit_done = is_div ? div_done : mul_done;
  assign step_fire = is_work && pend_q && unit_done;

  // step arithmetic on unit results
  logic signed [63:0] t_x1, t_den, t_x2, t_b5, q64, x3b, b3v, x3c, y2, pv;
  logic [16:0]        mc_mag;
  logic [63:0]        den_mag;
  logic [31:0]        b7_diff, q32;

  assign t_x1    = tdiv_pow2(mul_prod, 6'd15);
  assign t_den   = t_x1 + 64'(md_s);
  assign mc_mag  = mc_s[15] ? (17'd0 - {1'b1, mc_s}) : {1'b0, mc_s};
  assign den_mag = den_q[63] ? (64'd0 - den_q) : den_q;
  assign q64     = $signed({32'd0, div_quot});
  assign t_x2    = (mc_s[15] ^ den_q[63]) ? -q64 : q64;
  assign t_b5    = x_q + t_x2;
  assign x3b     = x_q + tdiv_pow2(mul_prod, 6'd11);
  assign b3v     = tdiv_pow2((((64'(ac1_s) <<< 2) + x3b) <<< oss_q) + 64'sd2, 6'd2);
  assign x3c     = tdiv_pow2(x_q + tdiv_pow2(mul_prod, 6'd16) + 64'sd2, 6'd2);
  assign b7_diff = {8'd0, ut_up_q} - b3_q;
  assign q32     = b7_q[31] ? {div_quot[30:0], 1'b0} : div_quot;
  assign y2      = tdiv_pow2(mul_prod, 6'd16);
  assign pv      = $signed(p_q) + tdiv_pow2(y1_q + y2 + CorrConst, 6'd4);

  // unit operand select
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      S_T_MUL: begin
        mul_a = 64'($signed({1'b0, ut_up_q[15:0]}) - $signed({1'b0, ac6_u}));
        mul_b = {16'd0, ac5_u};
      end
      S_T_DIV: begin
        div_dividend = {4'd0, mc_mag, 11'd0};
        div_divisor  = den_mag[31:0];
      end
      S_P_SQ: begin
        mul_a = b6_q;
        mul_b = b6_q[31:0];
      end
      S_P_X1: begin
        mul_a = sq_q;
        mul_b = 32'(b2_s);
      end
      S_P_B3: begin
        mul_a = b6_q;
        mul_b = 32'(ac2_s);
      end
      S_P_C1: begin
        mul_a = b6_q;
        mul_b = 32'(ac3_s);
      end
      S_P_C2: begin
        mul_a = sq_q;
        mul_b = 32'(b1_s);
      end
      S_P_B4: begin
        mul_a = $signed({32'd0, u_q});
        mul_b = {16'd0, ac4_u};
      end
      S_P_B7: begin
        mul_a = $signed({32'd0, b7_diff});
        mul_b = {16'd0, B7Scale >> oss_q};
      end
      S_P_DIV: begin
        div_dividend = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
        div_divisor  = b4_q;
      end
      S_P_Y1A: begin
        mul_a = $signed(p_q >> 8);
        mul_b = p_q[39:8];
      end
      S_P_Y1B: begin
        mul_a = y1_q;
        mul_b = CorrSq;
      end
      S_P_Y2: begin
        mul_a = $signed(p_q);
        mul_b = CorrLin;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    if (is_work) begin
      if (!pend_q) begin
        // kick the unit on the first cycle of each step
        pend_d    = 1'b1;
        mul_start = !is_div;
        div_start = is_div;
      end else if (unit_done) begin
        pend_d = 1'b0;
      end
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (operation_i == OpPress) ? S_P_SQ : S_T_MUL;
        end
      end
      S_T_MUL: if (step_fire) state_d = (t_den == 64'sd0) ? S_DONE : S_T_DIV;
      S_T_DIV: if (step_fire) state_d = S_DONE;
      S_P_SQ:  if (step_fire) state_d = S_P_X1;
      S_P_X1:  if (step_fire) state_d = S_P_B3;
      S_P_B3:  if (step_fire) state_d = S_P_C1;
      S_P_C1:  if (step_fire) state_d = S_P_C2;
      S_P_C2:  if (step_fire) state_d = S_P_B4;
      S_P_B4:  if (step_fire) state_d = (mul_prod[31:15] == 17'd0) ? S_DONE : S_P_B7;
      S_P_B7:  if (step_fire) state_d = S_P_DIV;
      S_P_DIV: if (step_fire) state_d = S_P_Y1A;
      S_P_Y1A: if (step_fire) state_d = S_P_Y1B;
      S_P_Y1B: if (step_fire) state_d = S_P_Y2;
      S_P_Y2:  if (step_fire) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ac1_ac2_q   <= '0;
      ac3_ac4_q   <= '0;
      ac5_ac6_q   <= '0;
      b1_b2_q     <= '0;
      mc_md_q     <= '0;
      oss_q       <= 2'd3;
      b5_q        <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // keep B5 only from a temperature step that divided cleanly
      if ((state_q == S_T_DIV) && step_fire) begin
        b5_q <= t_b5[31:0];
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgAc1Ac2: ac1_ac2_q <= cfg_data_i;
          CfgAc3Ac4: ac3_ac4_q <= cfg_data_i;
          CfgAc5Ac6: ac5_ac6_q <= cfg_data_i;
          CfgB1B2:   b1_b2_q   <= cfg_data_i;
          CfgMcMd:   mc_md_q   <= cfg_data_i;
          CfgOss:    oss_q     <= cfg_data_i[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= operation_i;
      // temperature keeps the low word; pressure drops the unused low bits
      ut_up_q   <= (operation_i == OpPress) ?
                   (raw_reading_i >> (4'd8 - {2'd0, oss_q})) : raw_reading_i;
      b6_q      <= 64'(b5_q) - B6Offset;
      res_err_q <= 1'b0;
      res_val_q <= '0;
    end
    if (step_fire) begin
      case (state_q)
        S_T_MUL: begin
          x_q   <= t_x1;
          den_q <= t_den;
          if (t_den == 64'sd0) begin
            res_err_q <= 1'b1;
          end
        end
        S_T_DIV: res_val_q <= sat_value(tdiv_pow2(t_b5 + 64'sd8, 6'd4));
        S_P_SQ:  sq_q <= tdiv_pow2(mul_prod, 6'd12);
        S_P_X1:  x_q  <= tdiv_pow2(mul_prod, 6'd11);
        S_P_B3:  b3_q <= b3v[31:0];
        S_P_C1:  x_q  <= tdiv_pow2(mul_prod, 6'd13);
        S_P_C2:  u_q  <= 32'(x3c + 64'sd32768);
        S_P_B4: begin
          b4_q <= {15'd0, mul_prod[31:15]};
          if (mul_prod[31:15] == 17'd0) begin
            res_err_q <= 1'b1;
          end
        end
        S_P_B7:  b7_q <= mul_prod[31:0];
        S_P_DIV: p_q  <= {32'd0, q32};
        S_P_Y1A: y1_q <= mul_prod;
        S_P_Y1B: y1_q <= tdiv_pow2(mul_prod, 6'd16);
        S_P_Y2:  res_val_q <= sat_value(pv);
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_kind_q <= op_q;
      out_err_q  <= res_err_q;
      out_val_q  <= res_val_q;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign value_o        = out_val_q;
  assign divide_error_o = out_err_q;

  // an accepted transaction always leaves idle for at least one step
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a transaction is in flight");

  // a unit never reports completion while nothing was issued
  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done || div_done) |-> pend_q)
    else $error("unit finished without a pending step");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_error_o) |-> (value_o == 21'sd0))
    else $error("error result with nonzero value");

  // B5 only moves at the end of a temperature divide
  a_b5_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(b5_q) |-> $past(state_q == S_T_DIV))
    else $error("B5 changed outside a temperature step");

endmodule

`default_nettype wire
